[hdl/ust_pkg.sv]
`default_nettype none

package ust_pkg;

   localparam int MAX_DIVISIONS = 256;
   localparam int DIV_W         = 9;
   localparam int CELL_W        = 8;
   localparam int CORNERS       = 6;

   localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(16);
   localparam logic [DIV_W-1:0] DIV_MAX   = DIV_W'(MAX_DIVISIONS);

   localparam logic [37:0] PI_HALF_Q30 = 38'd1686629713;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [16:0] TEX_ONE     = 17'h1_0000;
   localparam logic [15:0] POS_MAX     = 16'd32767;

   localparam int NUM_W       = 38;
   localparam int DIV_PER_STG = 2;
   localparam int DIV_STAGES  = NUM_W / DIV_PER_STG;
   localparam int H_STEPS     = 4;

   localparam int ST_RED  = 0;
   localparam int ST_QR   = 1;
   localparam int ST_FOLD = 2;
   localparam int ST_NUM  = 3;
   localparam int ST_DIV0 = 4;
   localparam int ST_X    = ST_DIV0 + DIV_STAGES;
   localparam int ST_H0   = ST_X + 1;
   localparam int ST_TRIG = ST_H0 + 3 * H_STEPS;
   localparam int ST_MUL  = ST_TRIG + 1;
   localparam int ST_OUT  = ST_MUL + 1;
   localparam int NST     = ST_OUT + 1;

   // lanes: 0 sin phi, 1 cos phi, 2 sin theta, 3 cos theta
   localparam logic [5:0] H_DIV [4][4] = '{
      '{6'd42, 6'd20, 6'd6,  6'd1},
      '{6'd56, 6'd30, 6'd12, 6'd2},
      '{6'd42, 6'd20, 6'd6,  6'd1},
      '{6'd56, 6'd30, 6'd12, 6'd2}
   };

   localparam logic [31:0] H_RCP [4][4] = '{
      '{32'd102261126, 32'd214748364, 32'd715827882, 32'd0},
      '{32'd76695844,  32'd143165576, 32'd357913941, 32'd2147483648},
      '{32'd102261126, 32'd214748364, 32'd715827882, 32'd0},
      '{32'd76695844,  32'd143165576, 32'd357913941, 32'd2147483648}
   };

   typedef struct packed {
      logic                   bad;
      logic                   last;
      logic [1:0]             corner;
      logic [8:0]             a;
      logic [8:0]             b;
      logic [1:0][10:0]       n;
      logic [1:0][1:0]        q;
      logic [1:0]             sw;
      logic [1:0][8:0]        r;
      logic [3:0][NUM_W-1:0]  nq;
      logic [3:0][8:0]        rem;
      logic [1:0][29:0]       x;
      logic [1:0][29:0]       x2;
      logic [3:0][30:0]       t;
      logic [3:0][29:0]       p;
      logic [3:0][29:0]       q0;
      logic [16:0]            tex_u;
      logic [16:0]            tex_v;
      logic [1:0][30:0]       sn;
      logic [1:0][30:0]       cs;
      logic [1:0]             sn_neg;
      logic [1:0]             cs_neg;
      logic [61:0]            mx;
      logic [61:0]            mz;
      logic                   nx;
      logic                   nz;
      logic [15:0]            pos_x;
      logic [15:0]            pos_y;
      logic [15:0]            pos_z;
   } vtx_type;

   function automatic logic [1:0] corner_of(input logic [2:0] idx);
      case (idx)
         3'd0:    corner_of = 2'd0;
         3'd1:    corner_of = 2'd1;
         3'd2:    corner_of = 2'd2;
         3'd3:    corner_of = 2'd1;
         3'd4:    corner_of = 2'd3;
         3'd5:    corner_of = 2'd2;
         default: corner_of = 2'd0;
      endcase
   endfunction

   function automatic logic [15:0] q15_pack(input logic [16:0] m, input logic neg);
      logic [15:0] m16;
      m16 = (m > {1'b0, POS_MAX}) ? POS_MAX : m[15:0];
      q15_pack = neg ? (16'd0 - m16) : m16;
   endfunction

endpackage

`default_nettype wire

[hdl/uv_sphere_tessellator_core.sv]
// uv sphere cell tessellator
// req channel: one cell per transfer, req_tdata = {lon_cell, lat_cell}.
// rsp channel: six vertices per valid cell in the order p0 p1 p2 p1 p3 p2,
// rsp_tlast on the sixth; a cell at or beyond divisions gives one vertex with
// bad_cell set, all data zero and rsp_tlast high.
// csr_wr_en writes divisions (values above 256 are stored as 256); write only
// while the block is idle.
// throughput: one vertex per cycle while rsp_tready is high, so a valid cell gives six
// vertices and a bad cell one; the vertex sequencer at the input sets this rate.
// the path from a cell transfer to its first vertex includes the sequencer, a 19-stage
// restoring divider, two quotient bits per stage, and a 12-stage polynomial pipeline.
// a new cell is taken in the cycle in which the previous one issues its last vertex.
// rsp_tvalid high with rsp_tready low holds the pipeline; nothing is lost or repeated.
// reset (synchronous, active high) empties the pipeline and sets divisions to 16.
`default_nettype none

module uv_sphere_tessellator_core
   import ust_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [8:0]  csr_wr_data,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // lat_cell, lon_cell
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [87:0] rsp_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
   output      logic [2:0]  rsp_tuser,   // corner, bad_cell
   output      logic        rsp_tlast
);

   logic [DIV_W-1:0]  divisions_ff;
   logic              busy_ff;
   logic              busy_in;
   logic [CELL_W-1:0] lat_ff;
   logic [CELL_W-1:0] lon_ff;
   logic              bad_ff;
   logic [2:0]        cnt_ff;
   logic [2:0]        cnt_in;

   logic              en;
   logic              issue;
   logic              done;
   logic              req_xfer;
   logic              req_bad;

   vtx_type           stg_ff [NST];
   vtx_type           stg_in [NST];
   logic [NST-1:0]    vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisions_ff <= DIV_RESET;
      end else if (csr_wr_en) begin
         divisions_ff <= (csr_wr_data > DIV_MAX) ? DIV_MAX : csr_wr_data;
      end
   end

   // vertex sequencer
   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign issue      = busy_ff && en;
   assign done       = issue && (bad_ff || cnt_ff == 3'(CORNERS - 1));
   assign req_tready = !busy_ff || done;
   assign req_xfer   = req_tvalid && req_tready;
   assign req_bad    = ({1'b0, req_tdata[7:0]} >= divisions_ff) ||
                       ({1'b0, req_tdata[15:8]} >= divisions_ff);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (issue) begin
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      if (req_xfer) begin
         lat_ff <= req_tdata[7:0];
         lon_ff <= req_tdata[15:8];
         bad_ff <= req_bad;
      end
   end

   // stage 0: corner indices and angle reduction
   always_comb begin
      vtx_type     v;
      logic [1:0]  cn;
      logic [10:0] four_s;
      v      = '0;
      cn     = bad_ff ? 2'd0 : corner_of(cnt_ff);
      four_s = {divisions_ff, 2'b00};
      v.bad    = bad_ff;
      v.last   = bad_ff || (cnt_ff == 3'(CORNERS - 1));
      v.corner = cn;
      v.a      = bad_ff ? 9'd0 : {1'b0, lat_ff} + {8'd0, cn[1]};
      v.b      = bad_ff ? 9'd0 : {1'b0, lon_ff} + {8'd0, cn[0]};
      v.n[0]   = {1'b0, v.a, 1'b0} + {2'b00, divisions_ff} + {1'b0, divisions_ff, 1'b0};
      v.n[1]   = {v.b, 2'b00};
      for (int l = 0; l < 2; l++) begin
         if (v.n[l] >= four_s) begin
            v.n[l] = v.n[l] - four_s;
         end
      end
      stg_in[ST_RED] = v;
   end

   for (genvar g = 1; g < NST; g++) begin : g_stage
      if (g == ST_QR) begin : g_qr
         always_comb begin
            vtx_type     v;
            logic [10:0] s1;
            logic [10:0] s2;
            logic [10:0] s3;
            logic [10:0] base;
            v  = stg_ff[g-1];
            s1 = {2'b00, divisions_ff};
            s2 = {1'b0, divisions_ff, 1'b0};
            s3 = s1 + s2;
            for (int l = 0; l < 2; l++) begin
               if (v.n[l] >= s3) begin
                  v.q[l] = 2'd3;
                  base   = s3;
               end else if (v.n[l] >= s2) begin
                  v.q[l] = 2'd2;
                  base   = s2;
               end else if (v.n[l] >= s1) begin
                  v.q[l] = 2'd1;
                  base   = s1;
               end else begin
                  v.q[l] = 2'd0;
                  base   = 11'd0;
               end
               v.r[l] = 9'(v.n[l] - base);
            end
            stg_in[g] = v;
         end
      end else if (g == ST_FOLD) begin : g_fold
         always_comb begin
            vtx_type v;
            v = stg_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               v.sw[l] = {v.r[l], 1'b0} > {1'b0, divisions_ff};
               if (v.sw[l]) begin
                  v.r[l] = divisions_ff - v.r[l];
               end
            end
            stg_in[g] = v;
         end
      end else if (g == ST_NUM) begin : g_num
         always_comb begin
            vtx_type          v;
            logic [NUM_W-1:0] half_s;
            v      = stg_ff[g-1];
            half_s = {30'd0, divisions_ff[8:1]};
            for (int l = 0; l < 2; l++) begin
               v.nq[l] = {29'd0, v.r[l]} * PI_HALF_Q30 + half_s;
            end
            v.nq[2] = {13'd0, v.b, 16'd0} + half_s;
            v.nq[3] = {13'd0, v.a, 16'd0} + half_s;
            v.rem   = '0;
            stg_in[g] = v;
         end
      end else if (g >= ST_DIV0 && g < ST_X) begin : g_div
         always_comb begin
            vtx_type    v;
            logic [9:0] t10;
            logic       ge;
            v = stg_ff[g-1];
            for (int j = 0; j < 4; j++) begin
               for (int s = 0; s < DIV_PER_STG; s++) begin
                  t10      = {v.rem[j], v.nq[j][NUM_W-1]};
                  ge       = t10 >= {1'b0, divisions_ff};
                  v.nq[j]  = {v.nq[j][NUM_W-2:0], ge};
                  v.rem[j] = ge ? 9'(t10 - {1'b0, divisions_ff}) : t10[8:0];
               end
            end
            stg_in[g] = v;
         end
      end else if (g == ST_X) begin : g_x
         always_comb begin
            vtx_type     v;
            logic [59:0] sq;
            v = stg_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               v.x[l]  = v.nq[l][29:0];
               sq      = {30'd0, v.x[l]} * {30'd0, v.x[l]};
               v.x2[l] = sq[59:30];
            end
            v.tex_u = v.nq[2][16:0];
            v.tex_v = TEX_ONE - v.nq[3][16:0];
            for (int j = 0; j < 4; j++) begin
               v.t[j] = Q30_ONE;
            end
            stg_in[g] = v;
         end
      end else if (g >= ST_H0 && g < ST_TRIG) begin : g_horner
         localparam int K   = (g - ST_H0) / 3;
         localparam int SUB = (g - ST_H0) % 3;
         always_comb begin
            vtx_type     v;
            logic [60:0] prod;
            logic [61:0] prd;
            logic [31:0] mulq;
            logic [31:0] rm;
            logic [29:0] qv;
            logic        fin;
            v = stg_ff[g-1];
            for (int j = 0; j < 4; j++) begin
               fin = (j % 2 == 0) && (K == H_STEPS - 1);
               case (SUB)
                  0: begin
                     if (fin) begin
                        prod   = {31'd0, v.x[j/2]} * {30'd0, v.t[j]};
                        v.t[j] = prod[60:30];
                     end else begin
                        prod   = {31'd0, v.x2[j/2]} * {30'd0, v.t[j]};
                        v.p[j] = prod[59:30];
                     end
                  end
                  1: begin
                     if (!fin) begin
                        prd     = {32'd0, v.p[j]} * {30'd0, H_RCP[j][K]};
                        v.q0[j] = prd[61:32];
                     end
                  end
                  default: begin
                     if (!fin) begin
                        mulq   = {2'b00, v.q0[j]} * {26'd0, H_DIV[j][K]};
                        rm     = {2'b00, v.p[j]} - mulq;
                        qv     = v.q0[j] + {29'd0, rm >= {26'd0, H_DIV[j][K]}};
                        v.t[j] = Q30_ONE - {1'b0, qv};
                     end
                  end
               endcase
            end
            stg_in[g] = v;
         end
      end else if (g == ST_TRIG) begin : g_trig
         always_comb begin
            vtx_type     v;
            logic [30:0] ls;
            logic [30:0] lc;
            v = stg_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               ls = v.sw[l] ? v.t[2*l+1] : v.t[2*l];
               lc = v.sw[l] ? v.t[2*l]   : v.t[2*l+1];
               case (v.q[l])
                  2'd0: begin
                     v.sn[l] = ls; v.sn_neg[l] = 1'b0;
                     v.cs[l] = lc; v.cs_neg[l] = 1'b0;
                  end
                  2'd1: begin
                     v.sn[l] = lc; v.sn_neg[l] = 1'b0;
                     v.cs[l] = ls; v.cs_neg[l] = 1'b1;
                  end
                  2'd2: begin
                     v.sn[l] = ls; v.sn_neg[l] = 1'b1;
                     v.cs[l] = lc; v.cs_neg[l] = 1'b1;
                  end
                  default: begin
                     v.sn[l] = lc; v.sn_neg[l] = 1'b1;
                     v.cs[l] = ls; v.cs_neg[l] = 1'b0;
                  end
               endcase
            end
            stg_in[g] = v;
         end
      end else if (g == ST_MUL) begin : g_mul
         always_comb begin
            vtx_type     v;
            logic [31:0] ry;
            v       = stg_ff[g-1];
            v.mx    = {31'd0, v.cs[0]} * {31'd0, v.cs[1]};
            v.mz    = {31'd0, v.cs[0]} * {31'd0, v.sn[1]};
            v.nx    = v.cs_neg[0] ^ v.cs_neg[1];
            v.nz    = v.cs_neg[0] ^ v.sn_neg[1];
            ry      = {1'b0, v.sn[0]} + 32'h0000_4000;
            v.pos_y = q15_pack(ry[31:15], v.sn_neg[0]);
            stg_in[g] = v;
         end
      end else begin : g_out
         always_comb begin
            vtx_type     v;
            logic [61:0] rx;
            logic [61:0] rz;
            v       = stg_ff[g-1];
            rx      = v.mx + 62'h1000_0000_0000;
            rz      = v.mz + 62'h1000_0000_0000;
            v.pos_x = q15_pack(rx[61:45], v.nx);
            v.pos_z = q15_pack(rz[61:45], v.nz);
            if (v.bad) begin
               v.pos_x = '0;
               v.pos_y = '0;
               v.pos_z = '0;
               v.tex_u = '0;
               v.tex_v = '0;
            end
            stg_in[g] = v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], busy_ff};
      end
      if (en) begin
         stg_ff <= stg_in;
      end
   end

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = {6'd0, stg_ff[ST_OUT].tex_v, stg_ff[ST_OUT].tex_u,
                        stg_ff[ST_OUT].pos_z, stg_ff[ST_OUT].pos_y, stg_ff[ST_OUT].pos_x};
   assign rsp_tuser  = {stg_ff[ST_OUT].bad, stg_ff[ST_OUT].corner};
   assign rsp_tlast  = stg_ff[ST_OUT].last;

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < 3'(CORNERS))
      else $error("vertex count out of range");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tdata == '0 && rsp_tlast && rsp_tuser[1:0] == 2'd0))
      else $error("bad cell vertex carries data");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> busy_ff && cnt_ff == 3'd0)
      else $error("cell transfer not loaded into sequencer");
`endif

endmodule

`default_nettype wire
